FILE: hw/rtl/nmu_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and rounding helper for the nesterov momentum update block
package nmu_pkg;

    // field and storage geometry
    localparam int LAYER_W  = 3;
    localparam int ENTRY_W  = 12;
    localparam int LAYERS   = 1 << LAYER_W;
    localparam int SLOT_W   = LAYER_W + ENTRY_W;
    localparam int SLOTS    = 1 << SLOT_W;
    localparam int DATA_W   = 32;
    localparam int COEF_W   = 16;
    localparam int FRAC_W   = 16;

    // arithmetic widths
    localparam int PROD_W   = COEF_W + 1 + DATA_W;      // 17 x 32 signed product
    localparam int P2_W     = COEF_W + 2 + DATA_W;      // 18 x 32 signed product
    localparam int ACC_W    = P2_W + 2;                 // headroom for the final sum
    localparam int Q_W      = ACC_W - FRAC_W;
    localparam int RND_HALF = 1 << (FRAC_W - 1);

    // configuration port
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;
    localparam logic [COEF_W-1:0] LR_RESET = 16'd655;
    localparam logic [COEF_W-1:0] MU_RESET = 16'd58982;

    typedef enum logic {
        REG_LEARNING_RATE = 1'b0,
        REG_MOMENTUM      = 1'b1
    } t_reg_idx;

    typedef enum logic {
        OP_UPDATE = 1'b0,
        OP_CLEAR  = 1'b1
    } t_op;

    // item leaving the velocity fetch stage
    typedef struct packed {
        logic              valid;
        logic [SLOT_W-1:0] slot;
        logic [DATA_W-1:0] v;
        logic [DATA_W-1:0] grad;
        logic [DATA_W-1:0] weight;
    } t_s2;

    // one forwarding tap: a new velocity not yet visible at the memory read port
    typedef struct packed {
        logic              valid;
        logic [SLOT_W-1:0] slot;
        logic [DATA_W-1:0] nv;
    } t_fwd_tap;

    typedef struct packed {
        t_fwd_tap s3;
        t_fwd_tap s4;
        t_fwd_tap s5;
    } t_fwd;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              sat;
    } t_rnd;

    // round a Q.32 value to Q16.16 (nearest, ties up) and saturate to 32 bits
    function automatic t_rnd rnd_sat(input logic [ACC_W-1:0] x);
        logic [ACC_W-1:0] y;
        logic [Q_W-1:0]   q;
        t_rnd             r;
        y = x + ACC_W'(RND_HALF);
        q = y[ACC_W-1:FRAC_W];
        if (q[Q_W-1:DATA_W-1] == {(Q_W-DATA_W+1){q[Q_W-1]}}) begin
            r.value = q[DATA_W-1:0];
            r.sat   = 1'b0;
        end else begin
            r.sat   = 1'b1;
            r.value = q[Q_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

FILE: hw/rtl/nmu_ram.sv
`timescale 1ns / 1ps
// generic single-write, single-read memory with registered read data
module nmu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, old data on a same-address collision
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/nmu_apb_regs.sv
`timescale 1ns / 1ps
// apb configuration registers: learning rate and momentum
module nmu_apb_regs import nmu_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output logic [COEF_W-1:0] o_learning_rate,
    output logic [COEF_W-1:0] o_momentum
);

    logic              wr_req;
    t_reg_idx          reg_idx;
    logic [COEF_W-1:0] r_learning_rate;
    logic [COEF_W-1:0] r_momentum;

    assign pready  = 1'b1;
    assign wr_req  = psel && penable && pwrite && pready;
    assign reg_idx = t_reg_idx'(paddr[2]);

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_learning_rate <= LR_RESET;
            r_momentum      <= MU_RESET;
        end else if (wr_req) begin
            case (reg_idx)
                REG_LEARNING_RATE: r_learning_rate <= pwdata[COEF_W-1:0];
                REG_MOMENTUM:      r_momentum      <= pwdata[COEF_W-1:0];
                default:           r_momentum      <= r_momentum;
            endcase
        end
    end

    // read back
    always_comb begin
        case (reg_idx)
            REG_LEARNING_RATE: prdata = {{(APB_DW-COEF_W){1'b0}}, r_learning_rate};
            REG_MOMENTUM:      prdata = {{(APB_DW-COEF_W){1'b0}}, r_momentum};
            default:           prdata = '0;
        endcase
    end

    assign o_learning_rate = r_learning_rate;
    assign o_momentum      = r_momentum;

endmodule

FILE: hw/rtl/nmu_front.sv
`timescale 1ns / 1ps
// request intake, layer seen flags, velocity read and forwarding
module nmu_front import nmu_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_accept,
    input  logic               i_operation,
    input  logic [LAYER_W-1:0] i_layer_index,
    input  logic [ENTRY_W-1:0] i_entry_index,
    input  logic [DATA_W-1:0]  i_gradient,
    input  logic [DATA_W-1:0]  i_weight_in,
    input  logic               i_last_of_pass,
    input  logic [DATA_W-1:0]  i_ram_rdata,
    input  t_fwd               i_fwd,
    output logic               o_hazard,
    output logic               o_ram_re,
    output logic [SLOT_W-1:0]  o_ram_raddr,
    output t_s2                o_s2
);

    logic [SLOT_W-1:0] in_slot;
    logic              is_update;

    logic [LAYERS-1:0] r_layer_seen;

    logic              r_s1_valid;
    logic [SLOT_W-1:0] r_s1_slot;
    logic              r_s1_seen;
    logic [DATA_W-1:0] r_s1_grad;
    logic [DATA_W-1:0] r_s1_weight;

    logic [DATA_W-1:0] n_s2_v;
    logic              r_s2_valid;
    logic [SLOT_W-1:0] r_s2_slot;
    logic [DATA_W-1:0] r_s2_v;
    logic [DATA_W-1:0] r_s2_grad;
    logic [DATA_W-1:0] r_s2_weight;

    assign in_slot   = {i_layer_index, i_entry_index};
    assign is_update = (t_op'(i_operation) == OP_UPDATE);

    // an update to the slot just taken must wait for that slot's new velocity
    assign o_hazard = is_update && r_s1_valid && (r_s1_slot == in_slot);

    // velocity read issued whenever the pipe advances, data held while the pipe is stalled
    assign o_ram_re    = i_en;
    assign o_ram_raddr = in_slot;

    // layer seen flags, updated in request order
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_layer_seen <= '0;
        end else if (i_accept) begin
            if (!is_update) begin
                r_layer_seen <= '0;
            end else if (i_last_of_pass) begin
                r_layer_seen[i_layer_index] <= 1'b1;
            end
        end
    end

    // stage 1 control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_en) begin
            r_s1_valid <= i_accept && is_update;
        end
    end

    // stage 1 payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_slot   <= in_slot;
            r_s1_seen   <= r_layer_seen[i_layer_index];
            r_s1_grad   <= i_gradient;
            r_s1_weight <= i_weight_in;
        end
    end

    // old velocity: youngest in-flight write wins over the memory
    always_comb begin
        n_s2_v = i_ram_rdata;
        if (i_fwd.s5.valid && (i_fwd.s5.slot == r_s1_slot)) begin
            n_s2_v = i_fwd.s5.nv;
        end
        if (i_fwd.s4.valid && (i_fwd.s4.slot == r_s1_slot)) begin
            n_s2_v = i_fwd.s4.nv;
        end
        if (i_fwd.s3.valid && (i_fwd.s3.slot == r_s1_slot)) begin
            n_s2_v = i_fwd.s3.nv;
        end
        if (!r_s1_seen) begin
            n_s2_v = '0;
        end
    end

    // stage 2 control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (i_en) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    // stage 2 payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s2_slot   <= r_s1_slot;
            r_s2_v      <= n_s2_v;
            r_s2_grad   <= r_s1_grad;
            r_s2_weight <= r_s1_weight;
        end
    end

    assign o_s2.valid  = r_s2_valid;
    assign o_s2.slot   = r_s2_slot;
    assign o_s2.v      = r_s2_v;
    assign o_s2.grad   = r_s2_grad;
    assign o_s2.weight = r_s2_weight;

endmodule

FILE: hw/rtl/nmu_math.sv
`timescale 1ns / 1ps
// multiply, round and saturate stages for the new velocity and the new weight
module nmu_math import nmu_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic [COEF_W-1:0] i_learning_rate,
    input  logic [COEF_W-1:0] i_momentum,
    input  t_s2               i_s2,
    output t_fwd              o_fwd,
    output logic              o_ram_we,
    output logic [SLOT_W-1:0] o_ram_waddr,
    output logic [DATA_W-1:0] o_ram_wdata,
    output logic              o_valid,
    output logic [DATA_W-1:0] o_weight_out,
    output logic              o_saturated
);

    // stage 3: products
    logic signed [PROD_W-1:0] n_s3_muv;
    logic signed [PROD_W-1:0] n_s3_lrg;
    logic                     r_s3_valid;
    logic [SLOT_W-1:0]        r_s3_slot;
    logic [PROD_W-1:0]        r_s3_muv;
    logic [PROD_W-1:0]        r_s3_lrg;
    logic [DATA_W-1:0]        r_s3_weight;

    // stage 4: new velocity
    logic [ACC_W-1:0]         nv_acc;
    t_rnd                     n_s4_nv;
    logic                     r_s4_valid;
    logic [SLOT_W-1:0]        r_s4_slot;
    logic [DATA_W-1:0]        r_s4_nv;
    logic                     r_s4_sat;
    logic [PROD_W-1:0]        r_s4_muv;
    logic [DATA_W-1:0]        r_s4_weight;

    // stage 5: (1 + mu) * nv and w - mu * v
    logic signed [P2_W-1:0]   n_s5_p2;
    logic [P2_W-1:0]          n_s5_base;
    logic                     r_s5_valid;
    logic [SLOT_W-1:0]        r_s5_slot;
    logic [DATA_W-1:0]        r_s5_nv;
    logic                     r_s5_sat;
    logic [P2_W-1:0]          r_s5_p2;
    logic [P2_W-1:0]          r_s5_base;

    // output stage
    logic [ACC_W-1:0]         w_acc;
    t_rnd                     n_out;
    logic                     r_out_valid;
    logic [DATA_W-1:0]        r_out_weight;
    logic                     r_out_sat;

    // stage 3 products
    assign n_s3_muv = $signed({1'b0, i_momentum}) * $signed(i_s2.v);
    assign n_s3_lrg = $signed({1'b0, i_learning_rate}) * $signed(i_s2.grad);

    // nv = mu * v - lr * g, rounded and saturated
    assign nv_acc  = {{(ACC_W-PROD_W){r_s3_muv[PROD_W-1]}}, r_s3_muv}
                   - {{(ACC_W-PROD_W){r_s3_lrg[PROD_W-1]}}, r_s3_lrg};
    assign n_s4_nv = rnd_sat(nv_acc);

    // stage 5 terms
    assign n_s5_p2   = $signed({2'b01, i_momentum}) * $signed(r_s4_nv);
    assign n_s5_base = {{(P2_W-DATA_W-FRAC_W){r_s4_weight[DATA_W-1]}}, r_s4_weight,
                        {FRAC_W{1'b0}}}
                     - {{(P2_W-PROD_W){r_s4_muv[PROD_W-1]}}, r_s4_muv};

    // final sum, rounded and saturated
    assign w_acc = {{(ACC_W-P2_W){r_s5_base[P2_W-1]}}, r_s5_base}
                 + {{(ACC_W-P2_W){r_s5_p2[P2_W-1]}}, r_s5_p2};
    assign n_out = rnd_sat(w_acc);

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid  <= 1'b0;
            r_s4_valid  <= 1'b0;
            r_s5_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (i_en) begin
            r_s3_valid  <= i_s2.valid;
            r_s4_valid  <= r_s3_valid;
            r_s5_valid  <= r_s4_valid;
            r_out_valid <= r_s5_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s3_slot    <= i_s2.slot;
            r_s3_muv     <= n_s3_muv;
            r_s3_lrg     <= n_s3_lrg;
            r_s3_weight  <= i_s2.weight;

            r_s4_slot    <= r_s3_slot;
            r_s4_nv      <= n_s4_nv.value;
            r_s4_sat     <= n_s4_nv.sat;
            r_s4_muv     <= r_s3_muv;
            r_s4_weight  <= r_s3_weight;

            r_s5_slot    <= r_s4_slot;
            r_s5_nv      <= r_s4_nv;
            r_s5_sat     <= r_s4_sat;
            r_s5_p2      <= n_s5_p2;
            r_s5_base    <= n_s5_base;

            r_out_weight <= n_out.value;
            r_out_sat    <= r_s5_sat || n_out.sat;
        end
    end

    // velocity write-back as the item leaves stage 4
    assign o_ram_we    = i_en && r_s4_valid;
    assign o_ram_waddr = r_s4_slot;
    assign o_ram_wdata = r_s4_nv;

    // new velocities not yet readable from the memory
    assign o_fwd.s3.valid = r_s3_valid;
    assign o_fwd.s3.slot  = r_s3_slot;
    assign o_fwd.s3.nv    = n_s4_nv.value;
    assign o_fwd.s4.valid = r_s4_valid;
    assign o_fwd.s4.slot  = r_s4_slot;
    assign o_fwd.s4.nv    = r_s4_nv;
    assign o_fwd.s5.valid = r_s5_valid;
    assign o_fwd.s5.slot  = r_s5_slot;
    assign o_fwd.s5.nv    = r_s5_nv;

    assign o_valid      = r_out_valid;
    assign o_weight_out = r_out_weight;
    assign o_saturated  = r_out_sat;

endmodule

FILE: hw/rtl/nesterov_momentum_update.sv
`timescale 1ns / 1ps
// Nesterov momentum update, Q16.16, one parameter per request. A request enters on any cycle
// in which i_valid is high and o_stall is low; an update produces its result in the output
// register, a clear request produces none. The pipeline sustains one request per cycle while
// no result is held. The exception is an update to the same layer and entry as the update
// in stage 1: it is held, since the velocity read-modify-write through the momentum
// multiplier and rounding must end before the new velocity can be forwarded. Velocities
// live in a 32768 x 32 memory with no reset and no clearing pass; an update to a seen layer
// must only touch entries written since power-up. The whole pipeline holds while a result
// waits in the output register under i_stall. The user must write learning rate and momentum
// over APB (byte addresses 0 and 4) only while the block is idle; it is not enforced.
module nesterov_momentum_update import nmu_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,

    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [APB_AW-1:0]  paddr,
    input  logic [APB_DW-1:0]  pwdata,
    output logic [APB_DW-1:0]  prdata,
    output logic               pready,

    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_operation,
    input  logic [LAYER_W-1:0] i_layer_index,
    input  logic [ENTRY_W-1:0] i_entry_index,
    input  logic signed [DATA_W-1:0] i_gradient,
    input  logic signed [DATA_W-1:0] i_weight_in,
    input  logic               i_last_of_pass,

    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [DATA_W-1:0] o_weight_out,
    output logic               o_saturated
);

    logic              en;
    logic              hazard;
    logic              accept;
    logic [COEF_W-1:0] learning_rate;
    logic [COEF_W-1:0] momentum;
    logic              ram_re;
    logic [SLOT_W-1:0] ram_raddr;
    logic [DATA_W-1:0] ram_rdata;
    logic              ram_we;
    logic [SLOT_W-1:0] ram_waddr;
    logic [DATA_W-1:0] ram_wdata;
    logic [DATA_W-1:0] weight_out;
    logic              acc_upd;
    t_s2               s2;
    t_fwd              fwd;

    // pipeline advances unless a result is held at the output
    assign en      = !o_valid || !i_stall;
    assign o_stall = !en || hazard;
    assign accept  = i_valid && !o_stall;

    // configuration registers
    nmu_apb_regs u_regs (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .o_learning_rate (learning_rate),
        .o_momentum      (momentum)
    );

    // velocity store
    nmu_ram #(
        .WIDTH (DATA_W),
        .DEPTH (SLOTS)
    ) u_vel_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // intake, seen flags and velocity fetch
    nmu_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (en),
        .i_accept       (accept),
        .i_operation    (i_operation),
        .i_layer_index  (i_layer_index),
        .i_entry_index  (i_entry_index),
        .i_gradient     (i_gradient),
        .i_weight_in    (i_weight_in),
        .i_last_of_pass (i_last_of_pass),
        .i_ram_rdata    (ram_rdata),
        .i_fwd          (fwd),
        .o_hazard       (hazard),
        .o_ram_re       (ram_re),
        .o_ram_raddr    (ram_raddr),
        .o_s2           (s2)
    );

    // arithmetic stages and output register
    nmu_math u_math (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_en            (en),
        .i_learning_rate (learning_rate),
        .i_momentum      (momentum),
        .i_s2            (s2),
        .o_fwd           (fwd),
        .o_ram_we        (ram_we),
        .o_ram_waddr     (ram_waddr),
        .o_ram_wdata     (ram_wdata),
        .o_valid         (o_valid),
        .o_weight_out    (weight_out),
        .o_saturated     (o_saturated)
    );

    assign o_weight_out = $signed(weight_out);

    // checks
    assign acc_upd = accept && (t_op'(i_operation) == OP_UPDATE);

    // an update to the same slot is never taken in two consecutive cycles
    a_no_b2b_same_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && acc_upd && $past(acc_upd)) |->
        ({i_layer_index, i_entry_index} != $past({i_layer_index, i_entry_index})))
        else $error("update to same slot accepted back to back");

    // a held result freezes intake
    a_hold_blocks_intake: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |-> o_stall)
        else $error("request taken while result held");

    // velocity write-back only while the pipeline moves
    a_write_on_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> !(o_valid && i_stall))
        else $error("velocity written during stall");

endmodule

FILE: tb/sv/nmu_update_checker.sv
`timescale 1ns / 1ps
// scoreboard for the nesterov momentum update block: predicts every update, checks results and register reads
module nmu_update_checker import nmu_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,

    input  logic                     i_psel,
    input  logic                     i_penable,
    input  logic                     i_pwrite,
    input  logic                     i_pready,
    input  logic [APB_AW-1:0]        i_paddr,
    input  logic [APB_DW-1:0]        i_pwdata,
    input  logic [APB_DW-1:0]        i_prdata,

    input  logic                     i_req_valid,
    input  logic                     i_req_stall,
    input  logic                     i_req_operation,
    input  logic [LAYER_W-1:0]       i_req_layer,
    input  logic [ENTRY_W-1:0]       i_req_entry,
    input  logic signed [DATA_W-1:0] i_req_gradient,
    input  logic signed [DATA_W-1:0] i_req_weight,
    input  logic                     i_req_last,

    input  logic                     i_res_valid,
    input  logic                     i_res_stall,
    input  logic signed [DATA_W-1:0] i_res_weight,
    input  logic                     i_res_saturated,

    input  logic                     i_run_done,
    output int                       o_fail_count,
    output int                       o_pending,
    output int                       o_results,
    output int                       o_clipped,
    output int                       o_carried
);

    localparam logic [COEF_W-1:0] LR_AFTER_RESET = 16'd655;
    localparam logic [COEF_W-1:0] MU_AFTER_RESET = 16'd58982;
    localparam int                MAX_PRINTED    = 30;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     clipped;
    } t_fixed;

    typedef struct packed {
        logic signed [DATA_W-1:0] weight;
        logic                     saturated;
    } t_update_result;

    // predictor state
    t_update_result           expected_updates[$];
    logic signed [DATA_W-1:0] velocity [SLOTS];
    logic [LAYERS-1:0]        layer_seen;
    logic [COEF_W-1:0]        learning_rate;
    logic [COEF_W-1:0]        momentum;

    int fail_count   = 0;
    int result_count = 0;
    int clip_count   = 0;
    int carry_count  = 0;
    bit done_checked = 1'b0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_results    = 0;
        o_clipped    = 0;
        o_carried    = 0;
    end

    task automatic report_mismatch(input string what);
        fail_count++;
        if (fail_count <= MAX_PRINTED)
            $display("%0t ns  mismatch: %s", $time, what);
    endtask

    // Q.32 to Q16.16, nearest with ties up, clipped to 32 bits
    function automatic t_fixed round_to_q16(input longint acc);
        longint q;
        t_fixed r;
        q = (acc + 64'sd32768) >>> 16;
        if (q > 64'sd2147483647) begin
            r.value   = 32'h7fff_ffff;
            r.clipped = 1'b1;
        end else if (q < -64'sd2147483648) begin
            r.value   = 32'h8000_0000;
            r.clipped = 1'b1;
        end else begin
            r.value   = q[DATA_W-1:0];
            r.clipped = 1'b0;
        end
        return r;
    endfunction

    // velocity read-modify-write and new weight for one update request
    task automatic predict_update();
        logic [SLOT_W-1:0] slot;
        longint            old_v;
        longint            grad;
        longint            wgt;
        longint            mu;
        longint            acc;
        t_fixed            nv;
        t_fixed            w_new;
        t_update_result    want;
        slot  = {i_req_layer, i_req_entry};
        grad  = i_req_gradient;
        wgt   = i_req_weight;
        mu    = longint'(momentum);
        old_v = 0;
        if (layer_seen[i_req_layer]) begin
            old_v = longint'($signed(velocity[slot]));
            carry_count++;
        end
        acc = mu * old_v - longint'(learning_rate) * grad;
        nv  = round_to_q16(acc);
        velocity[slot] = nv.value;
        acc = wgt * 64'sd65536 - mu * old_v + (64'sd65536 + mu) * longint'($signed(nv.value));
        w_new = round_to_q16(acc);
        if (i_req_last)
            layer_seen[i_req_layer] = 1'b1;
        want.weight    = w_new.value;
        want.saturated = nv.clipped | w_new.clipped;
        expected_updates.push_back(want);
    endtask

    always @(posedge i_clk) begin : monitor
        t_reg_idx          reg_idx;
        logic [COEF_W-1:0] reg_value;
        t_update_result    want;
        if (!i_rst_n) begin
            expected_updates.delete();
            layer_seen    = '0;
            learning_rate = LR_AFTER_RESET;
            momentum      = MU_AFTER_RESET;
        end else begin
            // register port: track writes, check reads
            if (i_psel && i_penable && i_pready) begin
                reg_idx = t_reg_idx'(i_paddr[2]);
                if (i_pwrite) begin
                    case (reg_idx)
                        REG_LEARNING_RATE: learning_rate = i_pwdata[COEF_W-1:0];
                        REG_MOMENTUM:      momentum      = i_pwdata[COEF_W-1:0];
                        default:           momentum      = momentum;
                    endcase
                end else begin
                    reg_value = (reg_idx == REG_MOMENTUM) ? momentum : learning_rate;
                    if (i_prdata !== {{(APB_DW-COEF_W){1'b0}}, reg_value})
                        report_mismatch($sformatf("%s read %h, expected %h",
                            reg_idx.name(), i_prdata, reg_value));
                end
            end

            // result side
            if (i_res_valid && !i_res_stall) begin
                if (expected_updates.size() == 0) begin
                    report_mismatch($sformatf("result %h/%b with no update outstanding",
                        i_res_weight, i_res_saturated));
                end else begin
                    want = expected_updates.pop_front();
                    result_count++;
                    if (want.saturated)
                        clip_count++;
                    if (i_res_weight !== want.weight)
                        report_mismatch($sformatf("result %0d weight_out %h, expected %h",
                            result_count, i_res_weight, want.weight));
                    if (i_res_saturated !== want.saturated)
                        report_mismatch($sformatf("result %0d saturated %b, expected %b",
                            result_count, i_res_saturated, want.saturated));
                end
            end

            // request side
            if (i_req_valid && !i_req_stall) begin
                if (t_op'(i_req_operation) == OP_CLEAR)
                    layer_seen = '0;
                else
                    predict_update();
            end

            // leftovers at the end of the run
            if (i_run_done && !done_checked) begin
                done_checked = 1'b1;
                if (expected_updates.size() != 0)
                    report_mismatch($sformatf("%0d expected results never arrived",
                        expected_updates.size()));
            end
        end
        o_fail_count <= fail_count;
        o_pending    <= expected_updates.size();
        o_results    <= result_count;
        o_clipped    <= clip_count;
        o_carried    <= carry_count;
    end

endmodule

FILE: tb/sv/nesterov_momentum_update_tb.sv
`timescale 1ns / 1ps
// top of the nesterov momentum update testbench: clock, reset, stimulus and verdict
module nesterov_momentum_update_tb;
    import nmu_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 10;
    localparam int PHASES         = 7;
    localparam int PHASE_ITEMS    = 200;
    localparam int LIVE_MAX       = 64;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;

    logic                     psel = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite = 1'b0;
    logic [APB_AW-1:0]        paddr = '0;
    logic [APB_DW-1:0]        pwdata = '0;
    logic [APB_DW-1:0]        prdata;
    logic                     pready;

    logic                     i_valid = 1'b0;
    logic                     o_stall;
    logic                     i_operation = OP_UPDATE;
    logic [LAYER_W-1:0]       i_layer_index = '0;
    logic [ENTRY_W-1:0]       i_entry_index = '0;
    logic signed [DATA_W-1:0] i_gradient = '0;
    logic signed [DATA_W-1:0] i_weight_in = '0;
    logic                     i_last_of_pass = 1'b0;

    logic                     o_valid;
    logic                     i_stall = 1'b0;
    logic signed [DATA_W-1:0] o_weight_out;
    logic                     o_saturated;

    logic run_done = 1'b0;
    int   fail_count;
    int   pending;
    int   results;
    int   clipped;
    int   carried;

    // idling bounds, changed per phase
    int tx_max_gap = 0;
    int rx_max_gap = 18;

    int updates_sent   = 0;
    int clears_sent    = 0;
    int watchdog_count = 0;

    // stimulus-side bookkeeping: keeps seen-layer reads on written entries
    bit                 seen_layer   [LAYERS];
    bit                 slot_written [SLOTS];
    logic [ENTRY_W-1:0] live_entries [LAYERS][LIVE_MAX];
    int                 live_count   [LAYERS];

    logic [COEF_W-1:0] lr_plan     [PHASES];
    logic [COEF_W-1:0] mu_plan     [PHASES];
    int                tx_gap_plan [PHASES];
    int                rx_gap_plan [PHASES];

    always #2 i_clk = ~i_clk;

    nesterov_momentum_update dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_operation    (i_operation),
        .i_layer_index  (i_layer_index),
        .i_entry_index  (i_entry_index),
        .i_gradient     (i_gradient),
        .i_weight_in    (i_weight_in),
        .i_last_of_pass (i_last_of_pass),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_weight_out   (o_weight_out),
        .o_saturated    (o_saturated)
    );

    nmu_update_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_psel          (psel),
        .i_penable       (penable),
        .i_pwrite        (pwrite),
        .i_pready        (pready),
        .i_paddr         (paddr),
        .i_pwdata        (pwdata),
        .i_prdata        (prdata),
        .i_req_valid     (i_valid),
        .i_req_stall     (o_stall),
        .i_req_operation (i_operation),
        .i_req_layer     (i_layer_index),
        .i_req_entry     (i_entry_index),
        .i_req_gradient  (i_gradient),
        .i_req_weight    (i_weight_in),
        .i_req_last      (i_last_of_pass),
        .i_res_valid     (o_valid),
        .i_res_stall     (i_stall),
        .i_res_weight    (o_weight_out),
        .i_res_saturated (o_saturated),
        .i_run_done      (run_done),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_results       (results),
        .o_clipped       (clipped),
        .o_carried       (carried)
    );

    // result side: random stall before each result
    always begin : result_sink
        int hold;
        hold = $urandom_range(0, rx_max_gap);
        if (hold > 0) begin
            i_stall <= 1'b1;
            repeat (hold) @(posedge i_clk);
            i_stall <= 1'b0;
        end
        do @(posedge i_clk); while (!o_valid);
    end

    // watchdog on cycles without any accepted request, result or register access
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (psel && penable)) begin
            watchdog_count <= 0;
        end else if (watchdog_count >= WATCHDOG_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", watchdog_count);
            $display("Regression FAIL");
            $finish;
        end else begin
            watchdog_count <= watchdog_count + 1;
        end
    end

    // register access: setup phase, access phase until pready, then idle
    task automatic write_register(input t_reg_idx idx, input logic [COEF_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {{(APB_DW-COEF_W){1'b0}}, value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic read_register(input t_reg_idx idx);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // one request: random gap, then hold until accepted
    task automatic put_request(input t_op op, input logic [LAYER_W-1:0] layer,
                               input logic [ENTRY_W-1:0] entry, input logic [DATA_W-1:0] grad,
                               input logic [DATA_W-1:0] wgt, input logic last);
        int gap;
        gap = $urandom_range(0, tx_max_gap);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_operation    <= op;
        i_layer_index  <= layer;
        i_entry_index  <= entry;
        i_gradient     <= grad;
        i_weight_in    <= wgt;
        i_last_of_pass <= last;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic put_update(input logic [LAYER_W-1:0] layer, input logic [ENTRY_W-1:0] entry,
                              input logic [DATA_W-1:0] grad, input logic [DATA_W-1:0] wgt,
                              input logic last);
        logic [SLOT_W-1:0] slot;
        slot = {layer, entry};
        if (!slot_written[slot]) begin
            slot_written[slot] = 1'b1;
            if (live_count[layer] < LIVE_MAX) begin
                live_entries[layer][live_count[layer]] = entry;
                live_count[layer]++;
            end
        end
        if (last)
            seen_layer[layer] = 1'b1;
        updates_sent++;
        put_request(OP_UPDATE, layer, entry, grad, wgt, last);
    endtask

    // clear request with junk in the ignored fields
    task automatic put_clear();
        foreach (seen_layer[l])
            seen_layer[l] = 1'b0;
        clears_sent++;
        put_request(OP_CLEAR, LAYER_W'($urandom), ENTRY_W'($urandom), $urandom, $urandom,
                    1'($urandom));
    endtask

    // entries of a seen layer come only from ones already written
    function automatic logic [ENTRY_W-1:0] pick_entry(input int layer);
        if (seen_layer[layer] || (live_count[layer] > 0 && $urandom_range(0, 1) == 1))
            return live_entries[layer][$urandom_range(0, live_count[layer] - 1)];
        return ENTRY_W'($urandom);
    endfunction

    // Q16.16 operand: extremes, full range or near zero
    function automatic logic [DATA_W-1:0] rand_fixed();
        case ($urandom_range(0, 9))
            0:       return 32'h7fff_ffff;
            1:       return 32'h8000_0000;
            2, 3:    return $urandom;
            default: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
        endcase
    endfunction

    // mostly complete layer passes, plus stray updates, clears and unfinished passes
    task automatic run_random(input int count);
        int                 sent;
        int                 kind;
        int                 len;
        int                 layer;
        logic [ENTRY_W-1:0] entry;
        sent = 0;
        while (sent < count) begin
            kind  = $urandom_range(0, 99);
            layer = $urandom_range(0, LAYERS - 1);
            if (kind < 70) begin
                len   = $urandom_range(1, 12);
                entry = pick_entry(layer);
                for (int k = 0; k < len; k++) begin
                    if (k > 0 && $urandom_range(0, 9) >= 3)
                        entry = pick_entry(layer);
                    put_update(LAYER_W'(layer), entry, rand_fixed(), rand_fixed(),
                               k == len - 1);
                end
                sent += len;
            end else if (kind < 82) begin
                put_update(LAYER_W'(layer), pick_entry(layer), rand_fixed(), rand_fixed(),
                           1'($urandom_range(0, 1)));
                sent++;
            end else if (kind < 90) begin
                put_clear();
                sent++;
            end else begin
                len = $urandom_range(2, 6);
                for (int k = 0; k < len; k++)
                    put_update(LAYER_W'(layer), pick_entry(layer), rand_fixed(), rand_fixed(),
                               1'b0);
                sent += len;
            end
        end
    endtask

    // wait for every expected result, then let any trailing clear pass through
    task automatic drain_pipeline();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin : stimulus
        lr_plan     = '{16'd655, 16'd65535, 16'd0, 16'd1, 16'd0, 16'd32768, 16'd65535};
        mu_plan     = '{16'd58982, 16'd65535, 16'd0, 16'd65535, 16'd0, 16'd0, 16'd1};
        tx_gap_plan = '{18, 0, 18, 4, 18, 0, 18};
        rx_gap_plan = '{18, 18, 0, 4, 0, 0, 18};
        lr_plan[4]  = COEF_W'($urandom_range(0, 65535));
        mu_plan[4]  = COEF_W'($urandom_range(0, 65535));

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        read_register(REG_LEARNING_RATE);
        read_register(REG_MOMENTUM);

        // directed: extremes, same-entry runs, seen and unseen layers, clear, rounding ties
        tx_max_gap = 0;
        put_update(3'd0, 12'h000, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0);
        put_update(3'd7, 12'hfff, 32'h8000_0000, 32'h8000_0000, 1'b1);
        put_update(3'd7, 12'hfff, 32'hffff_ffff, 32'h0000_0000, 1'b0);
        put_update(3'd7, 12'hfff, 32'h0000_0001, 32'h7fff_ffff, 1'b1);
        put_update(3'd0, 12'h000, 32'h0001_0000, 32'h0000_0000, 1'b1);
        put_update(3'd0, 12'h000, 32'hffff_0000, 32'h0001_0000, 1'b0);
        put_update(3'd3, 12'h555, 32'h0001_0000, 32'h0002_0000, 1'b1);
        put_update(3'd3, 12'h555, 32'h7fff_ffff, 32'h8000_0000, 1'b0);
        put_update(3'd4, 12'haaa, 32'h8000_0000, 32'h7fff_ffff, 1'b1);
        put_update(3'd4, 12'haaa, 32'h7fff_ffff, 32'h8000_0000, 1'b0);
        put_clear();
        put_update(3'd7, 12'hfff, 32'h0000_0001, 32'hffff_ffff, 1'b0);
        put_update(3'd7, 12'hfff, 32'h0012_3456, 32'h0000_0000, 1'b1);
        put_update(3'd7, 12'hfff, 32'hffed_cba9, 32'h0000_0000, 1'b0);
        put_update(3'd5, 12'h001, 32'h0000_8000, 32'h0000_0000, 1'b0);
        put_update(3'd5, 12'h002, 32'hffff_8000, 32'h0000_0000, 1'b0);

        // random phases, one register setting each
        for (int phase = 0; phase < PHASES; phase++) begin
            drain_pipeline();
            write_register(REG_LEARNING_RATE, lr_plan[phase]);
            write_register(REG_MOMENTUM, mu_plan[phase]);
            read_register(REG_LEARNING_RATE);
            read_register(REG_MOMENTUM);
            tx_max_gap = tx_gap_plan[phase];
            rx_max_gap = rx_gap_plan[phase];
            run_random(PHASE_ITEMS);
        end
        drain_pipeline();

        run_done <= 1'b1;
        repeat (2) @(posedge i_clk);
        $display("run covered %0d updates (%0d with carried velocity, %0d saturated) and %0d clears",
                 updates_sent, carried, clipped, clears_sent);
        $display("over %0d register settings incl. both coefficient extremes, %0d results checked",
                 PHASES, results);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/nmu_pkg.sv
hw/rtl/nmu_ram.sv
hw/rtl/nmu_apb_regs.sv
hw/rtl/nmu_front.sv
hw/rtl/nmu_math.sv
hw/rtl/nesterov_momentum_update.sv
tb/sv/nmu_update_checker.sv
tb/sv/nesterov_momentum_update_tb.sv
